[src/pqkr_pkg.sv]
// Shared types, sizes and codes for the process queue with removal by key.
package pqkr_pkg;

   // Queue depth and stored id width.
   localparam int CAPACITY = 16;
   localparam int ID_BITS = 16;

   // Fixed field widths of the request and response beats.
   localparam int MODE_BITS = 3;
   localparam int PID_BITS = 16;
   localparam int HANDLE_BITS = 16;
   localparam int STATUS_BITS = 2;
   localparam int FILL_BITS = 5;

   // Derived sizes.
   localparam int SLOT_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int ENTRY_BITS = PID_BITS + HANDLE_BITS;

   // Mask that keeps the low ID_BITS bits of an incoming id.
   localparam logic [PID_BITS-1:0] ID_MASK =
      (ID_BITS >= PID_BITS) ? {PID_BITS{1'b1}}
                            : PID_BITS'((64'd1 << ID_BITS) - 64'd1);

   // Request modes.
   localparam logic [MODE_BITS-1:0] MODE_ENQUEUE = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_DEQUEUE = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_PEEK    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_FIND    = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_START   = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_NEXT    = 3'd6;

   // Response status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic [MODE_BITS-1:0]   mode;
      logic [PID_BITS-1:0]    proc_id;
      logic [HANDLE_BITS-1:0] proc_handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [PID_BITS-1:0]    out_id;
      logic [HANDLE_BITS-1:0] out_handle;
      logic [FILL_BITS-1:0]   fill_count;
      logic                   walk_more;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

   // Reports an entry count in the fixed width of the fill_count field.
   function automatic logic [FILL_BITS-1:0] fill_field(input logic [COUNT_BITS-1:0] count);
      logic [COUNT_BITS+FILL_BITS-1:0] wide;
      wide = {{FILL_BITS{1'b0}}, count};
      return wide[FILL_BITS-1:0];
   endfunction

endpackage

[src/pqkr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pqkr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/process_queue_with_key_removal_top.sv]
// Top level of the process queue: control sequencer around one entry RAM.
//
// Usage: a request beat on req_ (valid/ready) carries a mode, a process id
// and a handle; every request produces exactly one response beat on rsp_
// (valid/ready) with a status, the entry found, the fill count and whether
// the walk still points at an entry. Entries live in one RAM in arrival
// order, slot 0 being the head.
// Timing: one request is worked on at a time. Enqueue, start walk and
// refused requests go straight to the response; peek and walk next read
// one entry first. Dequeue reads the head and then closes the gap, moving
// one entry per cycle through the read pipeline. Find scans one slot per
// cycle through the RAM read port; remove scans and then closes the gap.
// The response sits in an output register, so a new request is taken as
// soon as the sequencer is idle, even while the previous response is
// stalled; the sequencer waits only if a second response is due then.
// Reset: clears the fill count and walk position; RAM contents need no
// clearing since only data read from slots below the fill count is used.
module process_queue_with_key_removal_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pqkr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pqkr_pkg::rsp_type rsp_data
);

   pqkr_pkg::state_type state_ff, state_in;

   logic [pqkr_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic [pqkr_pkg::COUNT_BITS-1:0]  walk_ff, walk_in;
   logic [pqkr_pkg::MODE_BITS-1:0]   mode_ff, mode_in;
   logic [pqkr_pkg::PID_BITS-1:0]    key_ff, key_in;
   logic [pqkr_pkg::COUNT_BITS-1:0]  rd_idx_ff, rd_idx_in;
   logic [pqkr_pkg::COUNT_BITS-1:0]  chk_idx_ff, chk_idx_in;
   logic                             chk_valid_ff, chk_valid_in;
   logic [pqkr_pkg::COUNT_BITS-1:0]  slot_ff, slot_in;
   logic [pqkr_pkg::STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic [pqkr_pkg::PID_BITS-1:0]    res_id_ff, res_id_in;
   logic [pqkr_pkg::HANDLE_BITS-1:0] res_handle_ff, res_handle_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pqkr_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                             wr_en;
   logic [pqkr_pkg::SLOT_BITS-1:0]   wr_addr;
   logic [pqkr_pkg::ENTRY_BITS-1:0]  wr_data;
   logic [pqkr_pkg::SLOT_BITS-1:0]   rd_addr;
   logic [pqkr_pkg::ENTRY_BITS-1:0]  rd_data;

   logic [pqkr_pkg::PID_BITS-1:0]    req_key;
   logic [pqkr_pkg::PID_BITS-1:0]    rd_id;
   logic [pqkr_pkg::HANDLE_BITS-1:0] rd_handle;
   logic                             queue_full;
   logic                             queue_empty;
   logic                             walk_open;
   logic                             scan_hit;
   logic                             sweep_done;
   logic                             rsp_free;
   logic [pqkr_pkg::COUNT_BITS-1:0]  chk_prev;

   // Entry store: id in the upper half, handle in the lower half.
   pqkr_ram #(
      .WIDTH (pqkr_pkg::ENTRY_BITS),
      .DEPTH (pqkr_pkg::CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared conditions.
   assign req_key     = req_data.proc_id & pqkr_pkg::ID_MASK;
   assign rd_id       = rd_data[pqkr_pkg::ENTRY_BITS-1 -: pqkr_pkg::PID_BITS];
   assign rd_handle   = rd_data[pqkr_pkg::HANDLE_BITS-1:0];
   assign queue_full  = (count_ff == pqkr_pkg::COUNT_BITS'(pqkr_pkg::CAPACITY));
   assign queue_empty = (count_ff == '0);
   assign walk_open   = (walk_ff < count_ff);
   assign scan_hit    = chk_valid_ff && (rd_id == key_ff);
   assign sweep_done  = !chk_valid_ff && (rd_idx_ff >= count_ff);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign chk_prev    = chk_idx_ff - 1'b1;

   assign req_ready = (state_ff == pqkr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pqkr_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_data.mode)
                  pqkr_pkg::MODE_DEQUEUE,
                  pqkr_pkg::MODE_PEEK: begin
                     state_in = queue_empty ? pqkr_pkg::ST_RESP : pqkr_pkg::ST_FETCH;
                  end
                  pqkr_pkg::MODE_NEXT: begin
                     state_in = walk_open ? pqkr_pkg::ST_FETCH : pqkr_pkg::ST_RESP;
                  end
                  pqkr_pkg::MODE_REMOVE,
                  pqkr_pkg::MODE_FIND: begin
                     state_in = pqkr_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = pqkr_pkg::ST_RESP;
                  end
               endcase
            end
         end
         pqkr_pkg::ST_FETCH: begin
            state_in = (mode_ff == pqkr_pkg::MODE_DEQUEUE) ? pqkr_pkg::ST_SHIFT
                                                           : pqkr_pkg::ST_RESP;
         end
         pqkr_pkg::ST_SCAN: begin
            if (scan_hit) begin
               state_in = (mode_ff == pqkr_pkg::MODE_REMOVE) ? pqkr_pkg::ST_SHIFT
                                                             : pqkr_pkg::ST_RESP;
            end else if (sweep_done) begin
               state_in = pqkr_pkg::ST_RESP;
            end
         end
         pqkr_pkg::ST_SHIFT: begin
            if (sweep_done) begin
               state_in = pqkr_pkg::ST_RESP;
            end
         end
         pqkr_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = pqkr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pqkr_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM access and response register loading.
   always_comb begin
      count_in      = count_ff;
      walk_in       = walk_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_valid_in  = chk_valid_ff;
      slot_in       = slot_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = {key_ff, res_handle_ff};
      rd_addr       = '0;

      case (state_ff)
         pqkr_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_data.mode;
               key_in        = req_key;
               res_status_in = pqkr_pkg::STATUS_NOTFOUND;
               res_id_in     = '0;
               res_handle_in = '0;
               rd_idx_in     = '0;
               chk_valid_in  = 1'b0;
               case (req_data.mode)
                  pqkr_pkg::MODE_ENQUEUE: begin
                     if (queue_full) begin
                        res_status_in = pqkr_pkg::STATUS_FULL;
                     end else begin
                        // Append at the tail and echo the stored entry.
                        wr_en         = 1'b1;
                        wr_addr       = count_ff[pqkr_pkg::SLOT_BITS-1:0];
                        wr_data       = {req_key, req_data.proc_handle};
                        count_in      = count_ff + 1'b1;
                        res_status_in = pqkr_pkg::STATUS_OK;
                        res_id_in     = req_key;
                        res_handle_in = req_data.proc_handle;
                     end
                  end
                  pqkr_pkg::MODE_START: begin
                     walk_in       = '0;
                     res_status_in = pqkr_pkg::STATUS_OK;
                  end
                  pqkr_pkg::MODE_NEXT: begin
                     rd_addr = walk_ff[pqkr_pkg::SLOT_BITS-1:0];
                     if (walk_open) begin
                        walk_in = walk_ff + 1'b1;
                     end
                  end
                  default: begin
                     // Dequeue and peek read the head; others need no read.
                     rd_addr = '0;
                  end
               endcase
            end
         end
         pqkr_pkg::ST_FETCH: begin
            res_status_in = pqkr_pkg::STATUS_OK;
            res_id_in     = rd_id;
            res_handle_in = rd_handle;
            // A dequeue closes the gap behind the head.
            slot_in      = '0;
            rd_idx_in    = pqkr_pkg::COUNT_BITS'(1);
            chk_valid_in = 1'b0;
         end
         pqkr_pkg::ST_SCAN: begin
            // One slot read per cycle; the data of the previous slot is compared.
            rd_addr = rd_idx_ff[pqkr_pkg::SLOT_BITS-1:0];
            if (scan_hit) begin
               res_status_in = pqkr_pkg::STATUS_OK;
               res_id_in     = rd_id;
               res_handle_in = rd_handle;
               slot_in       = chk_idx_ff;
               rd_idx_in     = chk_idx_ff + 1'b1;
               chk_valid_in  = 1'b0;
            end else begin
               chk_valid_in = (rd_idx_ff < count_ff);
               chk_idx_in   = rd_idx_ff;
               if (rd_idx_ff < count_ff) begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
         end
         pqkr_pkg::ST_SHIFT: begin
            // Read slot i + 1, write it into slot i on the following cycle.
            rd_addr = rd_idx_ff[pqkr_pkg::SLOT_BITS-1:0];
            if (chk_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_prev[pqkr_pkg::SLOT_BITS-1:0];
               wr_data = rd_data;
            end
            chk_valid_in = (rd_idx_ff < count_ff);
            chk_idx_in   = rd_idx_ff;
            if (rd_idx_ff < count_ff) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (sweep_done) begin
               count_in = count_ff - 1'b1;
               // Keep the walk on the same entry when one before it leaves.
               if (walk_ff > slot_ff) begin
                  walk_in = walk_ff - 1'b1;
               end
            end
         end
         pqkr_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = res_status_ff;
               rsp_data_in.out_id     = res_id_ff;
               rsp_data_in.out_handle = res_handle_ff;
               rsp_data_in.fill_count = pqkr_pkg::fill_field(count_ff);
               rsp_data_in.walk_more  = walk_open;
            end
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pqkr_pkg::ST_IDLE;
         count_ff     <= '0;
         walk_ff      <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_handle_ff <= res_handle_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

[sim/tb_process_queue_with_key_removal_top.sv]
// Self-checking testbench for the process queue with removal by key.
module tb_process_queue_with_key_removal_top;

   // Unused mode code; the block answers it as a no-op.
   localparam logic [pqkr_pkg::MODE_BITS-1:0] MODE_NOP = 3'd7;
   localparam int RANDOM_ITEMS = 1850;
   localparam int QUIET_LIMIT = 2000;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int IDLE_PCT = 38;

   // Shadow copy of the queue that predicts every response beat and checks
   // the beats that come back in order.
   class proc_queue_model;
      logic [pqkr_pkg::PID_BITS-1:0]    slot_ids[pqkr_pkg::CAPACITY];
      logic [pqkr_pkg::HANDLE_BITS-1:0] slot_handles[pqkr_pkg::CAPACITY];
      int unsigned                      fill;
      int unsigned                      walk_pos;
      pqkr_pkg::rsp_type                pending_rsps[$];
      int unsigned                      mismatch_count;

      function new();
         fill = 0;
         walk_pos = 0;
         mismatch_count = 0;
      endfunction

      // Removes one slot, moves the tail up and keeps the walk on its entry.
      function void close_gap(int unsigned slot);
         for (int unsigned i = slot; i + 1 < fill; i++) begin
            slot_ids[i] = slot_ids[i + 1];
            slot_handles[i] = slot_handles[i + 1];
         end
         fill--;
         if (walk_pos > slot) begin
            walk_pos--;
         end
      endfunction

      // Applies one accepted request beat and queues the response it causes.
      function void accept_request(pqkr_pkg::req_type req);
         pqkr_pkg::rsp_type             rsp;
         logic [pqkr_pkg::PID_BITS-1:0] key;
         int                            hit;
         key = req.proc_id & pqkr_pkg::ID_MASK;
         hit = -1;
         rsp = '0;
         rsp.status = pqkr_pkg::STATUS_NOTFOUND;
         case (req.mode)
            pqkr_pkg::MODE_ENQUEUE: begin
               if (fill >= pqkr_pkg::CAPACITY) begin
                  rsp.status = pqkr_pkg::STATUS_FULL;
               end else begin
                  slot_ids[fill] = key;
                  slot_handles[fill] = req.proc_handle;
                  fill++;
                  rsp.status = pqkr_pkg::STATUS_OK;
                  rsp.out_id = key;
                  rsp.out_handle = req.proc_handle;
               end
            end
            pqkr_pkg::MODE_DEQUEUE, pqkr_pkg::MODE_PEEK: begin
               if (fill > 0) begin
                  rsp.status = pqkr_pkg::STATUS_OK;
                  rsp.out_id = slot_ids[0];
                  rsp.out_handle = slot_handles[0];
                  if (req.mode == pqkr_pkg::MODE_DEQUEUE) begin
                     close_gap(0);
                  end
               end
            end
            pqkr_pkg::MODE_REMOVE, pqkr_pkg::MODE_FIND: begin
               for (int unsigned i = 0; i < fill; i++) begin
                  if (hit < 0 && slot_ids[i] == key) begin
                     hit = i;
                  end
               end
               if (hit >= 0) begin
                  rsp.status = pqkr_pkg::STATUS_OK;
                  rsp.out_id = slot_ids[hit];
                  rsp.out_handle = slot_handles[hit];
                  if (req.mode == pqkr_pkg::MODE_REMOVE) begin
                     close_gap(hit);
                  end
               end
            end
            pqkr_pkg::MODE_START: begin
               walk_pos = 0;
               rsp.status = pqkr_pkg::STATUS_OK;
            end
            pqkr_pkg::MODE_NEXT: begin
               if (walk_pos < fill) begin
                  rsp.status = pqkr_pkg::STATUS_OK;
                  rsp.out_id = slot_ids[walk_pos];
                  rsp.out_handle = slot_handles[walk_pos];
                  walk_pos++;
               end
            end
            default: begin
            end
         endcase
         rsp.fill_count = pqkr_pkg::FILL_BITS'(fill);
         rsp.walk_more = (walk_pos < fill);
         pending_rsps.push_back(rsp);
      endfunction

      // Compares one field and reports a difference.
      function bit field_ok(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            return 0;
         end
         return 1;
      endfunction

      // Checks one accepted response beat against the oldest prediction.
      function void check_response(pqkr_pkg::rsp_type got);
         pqkr_pkg::rsp_type want;
         bit                good;
         if (pending_rsps.size() == 0) begin
            $display("%0t: response beat with nothing expected, got %h", $time, got);
            mismatch_count++;
            return;
         end
         want = pending_rsps.pop_front();
         good = field_ok("status", want.status, got.status);
         good &= field_ok("out_id", want.out_id, got.out_id);
         good &= field_ok("out_handle", want.out_handle, got.out_handle);
         good &= field_ok("fill_count", want.fill_count, got.fill_count);
         good &= field_ok("walk_more", want.walk_more, got.walk_more);
         if (!good) begin
            mismatch_count++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   pqkr_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   pqkr_pkg::rsp_type rsp_data;

   proc_queue_model queue_model = new();
   bit want_rsp_hold = 0;
   bit no_idle = 0;
   int quiet_cycles = 0;

   process_queue_with_key_removal_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
   end
   always #5 clock = ~clock;

   // Beat monitor and watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      bit moved;
      moved = 0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            queue_model.accept_request(req_data);
            moved = 1;
         end
         if (rsp_valid && rsp_ready) begin
            queue_model.check_response(rsp_data);
            moved = 1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Response side: random back-pressure, plus one long hold when asked.
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (want_rsp_hold) begin
            want_rsp_hold = 0;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   function automatic pqkr_pkg::req_type make_request(
         logic [pqkr_pkg::MODE_BITS-1:0] mode,
         logic [pqkr_pkg::PID_BITS-1:0] id,
         logic [pqkr_pkg::HANDLE_BITS-1:0] handle);
      pqkr_pkg::req_type req;
      req.mode = mode;
      req.proc_id = id;
      req.proc_handle = handle;
      return req;
   endfunction

   // Ids mostly come from a small pool so that finds and removes hit.
   function automatic logic [pqkr_pkg::PID_BITS-1:0] random_id();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return pqkr_pkg::PID_BITS'($urandom_range(0, 7));
      end else if (pick < 80) begin
         return 16'hfff8 | pqkr_pkg::PID_BITS'($urandom_range(0, 7));
      end
      return pqkr_pkg::PID_BITS'($urandom_range(0, 65535));
   endfunction

   // Picks a request; enq_pct steers the queue toward full or empty.
   function automatic pqkr_pkg::req_type random_request(int enq_pct);
      logic [pqkr_pkg::MODE_BITS-1:0] mode;
      if ($urandom_range(0, 99) < enq_pct) begin
         mode = pqkr_pkg::MODE_ENQUEUE;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3:     mode = pqkr_pkg::MODE_DEQUEUE;
            4, 5:           mode = pqkr_pkg::MODE_PEEK;
            6, 7, 8, 9:     mode = pqkr_pkg::MODE_REMOVE;
            10, 11, 12:     mode = pqkr_pkg::MODE_FIND;
            13:             mode = pqkr_pkg::MODE_START;
            14, 15, 16, 17: mode = pqkr_pkg::MODE_NEXT;
            default:        mode = MODE_NOP;
         endcase
      end
      return make_request(mode, random_id(),
                          pqkr_pkg::HANDLE_BITS'($urandom_range(0, 65535)));
   endfunction

   // Offers one request beat after a random gap and waits until it is taken.
   task automatic send_request(input pqkr_pkg::req_type req);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Stops offering and waits until every predicted response has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (queue_model.pending_rsps.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Stimulus: directed corner cases, then random segments.
   initial begin : req_side
      int items_sent;
      int seg;
      int seg_len;
      int enq_pct;
      items_sent = 0;
      seg = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Dequeue, peek, next, find and remove on an empty queue, the unused mode and a walk restart.
      send_request(make_request(pqkr_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_PEEK, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_NEXT, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_FIND, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_REMOVE, 16'h0000, 16'h0000));
      send_request(make_request(MODE_NOP, 16'hffff, 16'hffff));
      send_request(make_request(pqkr_pkg::MODE_START, 16'h0000, 16'h0000));
      // Extreme ids and handles, plus a duplicated id.
      send_request(make_request(pqkr_pkg::MODE_ENQUEUE, 16'hffff, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_ENQUEUE, 16'h0000, 16'hffff));
      send_request(make_request(pqkr_pkg::MODE_ENQUEUE, 16'h0005, 16'ha5a5));
      send_request(make_request(pqkr_pkg::MODE_ENQUEUE, 16'h0005, 16'h5a5a));
      send_request(make_request(pqkr_pkg::MODE_PEEK, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_FIND, 16'h0005, 16'h0000));
      // Walk, then remove behind the walk position and at it.
      send_request(make_request(pqkr_pkg::MODE_START, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_NEXT, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_NEXT, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_REMOVE, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_NEXT, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_REMOVE, 16'h0005, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_REMOVE, 16'h0005, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_NEXT, 16'h0000, 16'h0000));
      // Append after the walk ended resumes the walk on the new entry.
      send_request(make_request(pqkr_pkg::MODE_ENQUEUE, 16'h1234, 16'h4321));
      send_request(make_request(pqkr_pkg::MODE_NEXT, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_NEXT, 16'h0000, 16'h0000));
      send_request(make_request(pqkr_pkg::MODE_FIND, 16'hffff, 16'h0000));

      // Random segments alternate between filling, draining and a mix.
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       enq_pct = 75;
            1:       enq_pct = 10;
            default: enq_pct = 40;
         endcase
         if (seg == 3) begin
            want_rsp_hold = 1;
         end
         no_idle = (seg >= 8 && seg < 14);
         seg_len = $urandom_range(20, 60);
         repeat (seg_len) begin
            send_request(random_request(enq_pct));
            items_sent++;
         end
         if (seg == 6 || seg % 9 == 8) begin
            wait_for_drain();
         end
         seg++;
      end

      // Let the last responses come back, then give the verdict.
      no_idle = 0;
      wait_for_drain();
      repeat (40) @(posedge clock);
      if (queue_model.mismatch_count == 0 && queue_model.pending_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
